>>> hdl/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// Types and constants shared by the number formatter's front end, queue and
// character sequencer.
// ----------------------------------------------------------------------------
package nta_pkg;

  typedef enum logic [2:0] {
    KIND_HEX16  = 3'd0,
    KIND_HEX8   = 3'd1,
    KIND_SDEC   = 3'd2,
    KIND_RDEC   = 3'd3,
    KIND_BIN8   = 3'd4,
    KIND_UDEC16 = 3'd5
  } kind_t;

  // Five BCD digits: the low five decimal digits of a magnitude.
  localparam int BCD_W = 20;

  // Converter passes, four bits per cycle.
  localparam logic [3:0] ITER_WIDE = 4'd8;
  localparam logic [3:0] ITER_HALF = 4'd4;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    kind_t             kind;
    logic              neg;
    logic [15:0]       raw;
    logic [BCD_W-1:0]  bcd;
  } job_t;

endpackage

>>> hdl/number_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Turns a number and a format kind into ASCII text, one character per item.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready, kind, value) takes one number per
// item; the output channel (out_valid/out_ready, character, last) sends its
// text one character per item, with last set on the final character.
// Kinds 6 and 7 are taken and produce no text.
// A hex or binary item passes the front end's job register, the queue and
// the sequencer's job registers on its way to the output register. Decimal
// kinds first pass a BCD converter taking four bits per cycle of the 32-bit
// magnitude (low 16 bits for unsigned 16-bit decimal); the front end takes
// the next item as it hands the finished job on. The output sends one
// character per cycle, without gaps while out_ready is high; 1 to 9 per job.
// A queue of QUEUE_DEPTH jobs sits between the converter and the sequencer,
// so new items keep being taken while the receiver stalls until the queue
// and the converter's holding register are full; then in_ready drops.
// Reset empties the queue, idles the front end and the sequencer and clears
// out_valid; nothing else persists between items.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter #(
  parameter int QUEUE_DEPTH = nta_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          kind,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          character,
  output logic                last
);

  logic           push_valid;
  logic           push_ready;
  nta_pkg::job_t  push_data;
  logic           pop_valid;
  logic           pop_ready;
  nta_pkg::job_t  pop_data;

  nta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .value      (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  nta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  nta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

endmodule

>>> hdl/nta_front.sv
// ----------------------------------------------------------------------------
// nta_front
// Accepts items, sorts them by kind and, for the decimal kinds, converts the
// magnitude to five BCD digits four bits per cycle before handing the job on.
// ----------------------------------------------------------------------------
module nta_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          kind,
  input  logic signed [31:0]  value,
  output logic                push_valid,
  input  logic                push_ready,
  output nta_pkg::job_t       push_data
);

  // Four double-dabble steps; digits carried out of the top are dropped, so
  // the result is the value modulo 100000.
  function automatic logic [nta_pkg::BCD_W-1:0] dabble4(
    input logic [nta_pkg::BCD_W-1:0] bcd_in,
    input logic [3:0]                bits
  );
    logic [nta_pkg::BCD_W-1:0] b;
    b = bcd_in;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < 5; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[nta_pkg::BCD_W-2:0], bits[s]};
    end
    return b;
  endfunction

  logic               busy;
  logic [3:0]         cnt;
  logic [31:0]        sh;
  nta_pkg::job_t      job;

  logic               accept;
  logic               kind_ok;
  logic [31:0]        raw;
  logic [31:0]        mag;
  logic [3:0]         load_cnt;
  logic [31:0]        load_sh;

  assign raw        = value;
  assign mag        = raw[31] ? (~raw + 32'd1) : raw;
  assign kind_ok    = (kind <= nta_pkg::KIND_UDEC16);
  assign push_valid = busy && (cnt == 4'd0);
  assign in_ready   = !busy || ((cnt == 4'd0) && push_ready);
  assign accept     = in_valid && in_ready;
  assign push_data  = job;

  always_comb begin
    unique case (kind) inside
      nta_pkg::KIND_SDEC, nta_pkg::KIND_RDEC: begin
        load_cnt = nta_pkg::ITER_WIDE;
        load_sh  = mag;
      end
      nta_pkg::KIND_UDEC16: begin
        load_cnt = nta_pkg::ITER_HALF;
        load_sh  = {raw[15:0], 16'd0};
      end
      default: begin
        load_cnt = 4'd0;
        load_sh  = raw;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 4'd0;
    end else if (accept) begin
      // Unused kinds give no text and are simply dropped.
      busy <= kind_ok;
      cnt  <= load_cnt;
    end else if (push_valid && push_ready) begin
      busy <= 1'b0;
    end else if (busy && (cnt != 4'd0)) begin
      cnt <= cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.kind <= nta_pkg::kind_t'(kind);
      job.neg  <= raw[31];
      job.raw  <= raw[15:0];
      job.bcd  <= '0;
      sh       <= load_sh;
    end else if (busy && (cnt != 4'd0)) begin
      job.bcd <= dabble4(job.bcd, sh[31:28]);
      sh      <= {sh[27:0], 4'd0};
    end
  end

endmodule

>>> hdl/nta_queue.sv
// ----------------------------------------------------------------------------
// nta_queue
// Short first-in first-out queue of converted jobs between the front end and
// the character sequencer.
// ----------------------------------------------------------------------------
module nta_queue #(
  parameter int DEPTH = nta_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  nta_pkg::job_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output nta_pkg::job_t  pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  nta_pkg::job_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hdl/nta_back.sv
// ----------------------------------------------------------------------------
// nta_back
// Character sequencer: takes one job at a time from the queue and sends its
// characters through an output register, one per cycle while out_ready allows.
// ----------------------------------------------------------------------------
module nta_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  nta_pkg::job_t  pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     character,
  output logic           last
);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] HEX_ALPHA  = 8'd7;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    c = {4'd0, nib} + CHAR_ZERO;
    if (nib > 4'd9) begin
      c = c + HEX_ALPHA;
    end
    return c;
  endfunction

  // Digit 0 is the ten-thousands digit, digit 4 the units.
  function automatic logic [3:0] digit_of(
    input logic [nta_pkg::BCD_W-1:0] bcd_in,
    input logic [2:0]                idx
  );
    logic [3:0] d;
    case (idx)
      3'd0:    d = bcd_in[19:16];
      3'd1:    d = bcd_in[15:12];
      3'd2:    d = bcd_in[11:8];
      3'd3:    d = bcd_in[7:4];
      default: d = bcd_in[3:0];
    endcase
    return d;
  endfunction

  // Slot 0 is the sign, slots 1 to 5 the decimal digits; hex and binary
  // text counts from slot 0 upwards.
  logic                        active;
  nta_pkg::kind_t              kind;
  logic                        neg;
  logic [15:0]                 raw;
  logic [nta_pkg::BCD_W-1:0]   bcd;
  logic [2:0]                  first;
  logic [3:0]                  slot;

  logic        advance;
  logic        is_last;
  logic        pop;
  logic [3:0]  end_slot;
  logic [3:0]  jump;
  logic [3:0]  slot_next;
  logic [3:0]  start_slot;
  logic [2:0]  head_first;
  logic [2:0]  digit_idx;
  logic [3:0]  dig;
  logic [3:0]  nib;
  logic [7:0]  cur_char;

  assign advance   = active && (!out_valid || out_ready);
  assign is_last   = (slot == end_slot);
  assign pop_ready = !active || (advance && is_last);
  assign pop       = pop_valid && pop_ready;
  assign digit_idx = 3'(slot - 4'd1);
  assign dig       = digit_of(bcd, digit_idx);

  always_comb begin
    unique case (kind) inside
      nta_pkg::KIND_HEX16: end_slot = 4'd3;
      nta_pkg::KIND_HEX8:  end_slot = 4'd1;
      nta_pkg::KIND_BIN8:  end_slot = 4'd8;
      default:             end_slot = 4'd5;
    endcase
  end

  // Position of the first significant digit; the units digit always counts.
  always_comb begin
    if (pop_data.bcd[19:16] != 4'd0) begin
      head_first = 3'd0;
    end else if (pop_data.bcd[15:12] != 4'd0) begin
      head_first = 3'd1;
    end else if (pop_data.bcd[11:8] != 4'd0) begin
      head_first = 3'd2;
    end else if (pop_data.bcd[7:4] != 4'd0) begin
      head_first = 3'd3;
    end else begin
      head_first = 3'd4;
    end
  end

  always_comb begin
    unique case (pop_data.kind) inside
      nta_pkg::KIND_RDEC:   start_slot = pop_data.neg ? 4'd0 : 4'd1;
      nta_pkg::KIND_UDEC16: start_slot = {1'b0, head_first} + 4'd1;
      default:              start_slot = 4'd0;
    endcase
  end

  always_comb begin
    unique case (kind) inside
      nta_pkg::KIND_SDEC, nta_pkg::KIND_UDEC16: jump = {1'b0, first} + 4'd1;
      default:                                  jump = 4'd1;
    endcase
    slot_next = (slot == 4'd0) ? jump : slot + 4'd1;
  end

  always_comb begin
    nib = 4'd0;
    unique case (kind) inside
      nta_pkg::KIND_HEX16: begin
        case (slot[1:0])
          2'd0:    nib = raw[15:12];
          2'd1:    nib = raw[11:8];
          2'd2:    nib = raw[7:4];
          default: nib = raw[3:0];
        endcase
        cur_char = hex_char(nib);
      end
      nta_pkg::KIND_HEX8: begin
        nib      = slot[0] ? raw[3:0] : raw[7:4];
        cur_char = hex_char(nib);
      end
      nta_pkg::KIND_BIN8: begin
        if (slot == 4'd8) begin
          cur_char = CHAR_B;
        end else begin
          cur_char = raw[3'd7 - slot[2:0]] ? CHAR_ONE : CHAR_ZERO;
        end
      end
      nta_pkg::KIND_SDEC, nta_pkg::KIND_RDEC, nta_pkg::KIND_UDEC16: begin
        if (slot == 4'd0) begin
          cur_char = neg ? CHAR_MINUS : CHAR_SPACE;
        end else if ((kind == nta_pkg::KIND_RDEC) && (digit_idx < first)) begin
          cur_char = CHAR_SPACE;
        end else begin
          cur_char = {4'd0, dig} + CHAR_ZERO;
        end
      end
      default: cur_char = CHAR_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (advance && is_last) begin
        active <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind  <= pop_data.kind;
      neg   <= pop_data.neg;
      raw   <= pop_data.raw;
      bcd   <= pop_data.bcd;
      first <= head_first;
      slot  <= start_slot;
    end else if (advance) begin
      slot <= slot_next;
    end
    if (advance) begin
      character <= cur_char;
      last      <= is_last;
    end
  end

`ifndef SYNTHESIS
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (slot <= end_slot))
    else $error("character slot ran past the end of its text");

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!active || (advance && is_last)))
    else $error("job taken from the queue while another is still being sent");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && is_last && !pop_valid) |=> !active)
    else $error("sequencer stayed busy after the final character");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the number formatter. Numbers of every format kind
// are sent through the input channel while an in-bench model builds the text
// that each should produce; every character from the output channel is
// compared with the oldest character still owed, and both sides idle and
// stall at random in some phases and run flat out in others.
// ----------------------------------------------------------------------------
module tb_top;

  // Kinds with no text; the block takes them and sends nothing.
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam logic [7:0] CHAR_ZERO  = "0";
  localparam logic [7:0] CHAR_ONE   = "1";
  localparam logic [7:0] CHAR_SPACE = " ";
  localparam logic [7:0] CHAR_MINUS = "-";
  localparam logic [7:0] CHAR_BIN   = "b";

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         kind;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         character;
  logic               last;

  // Each entry is {last, character}, oldest first.
  logic [8:0] owed_text[$];
  logic [8:0] owed_char;

  bit tx_idle_en;
  bit rx_idle_en;
  int rx_stall_left;
  int cycle_count;
  int error_count;
  int numbers_sent;
  int chars_checked;

  number_to_ascii_formatter DUT (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_char(input logic [7:0] ch);
    owed_text.push_back({1'b0, ch});
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    d = {4'd0, nib};
    if (nib > 4'd9) d = d + 8'd7;
    return d + CHAR_ZERO;
  endfunction

  // Low five decimal digits of mag; leading zeros dropped, or sent as
  // spaces when pad is set. The units digit always goes out.
  function automatic void push_decimal(input int unsigned mag, input bit pad);
    int unsigned scale;
    int unsigned digit;
    bit seen;
    scale = 10000;
    seen = 1'b0;
    for (int i = 0; i < 5; i++) begin
      digit = (mag / scale) % 10;
      if (digit != 0) seen = 1'b1;
      if (seen || i == 4) push_char(CHAR_ZERO + digit[7:0]);
      else if (pad) push_char(CHAR_SPACE);
      scale = scale / 10;
    end
  endfunction

  // Appends the text that one number should produce to owed_text.
  function automatic void predict_text(input logic [2:0] k, input logic [31:0] v);
    logic neg;
    int unsigned mag;
    int start;
    logic [8:0] tail;
    neg = v[31];
    mag = neg ? (32'd0 - v) : v;
    start = owed_text.size();
    case (k)
      nta_pkg::KIND_HEX16: begin
        for (int i = 3; i >= 0; i--) push_char(hex_digit(v[4*i +: 4]));
      end
      nta_pkg::KIND_HEX8: begin
        push_char(hex_digit(v[7:4]));
        push_char(hex_digit(v[3:0]));
      end
      nta_pkg::KIND_SDEC: begin
        push_char(neg ? CHAR_MINUS : CHAR_SPACE);
        push_decimal(mag, 1'b0);
      end
      nta_pkg::KIND_RDEC: begin
        if (neg) push_char(CHAR_MINUS);
        push_decimal(mag, 1'b1);
      end
      nta_pkg::KIND_BIN8: begin
        for (int i = 7; i >= 0; i--) push_char(v[i] ? CHAR_ONE : CHAR_ZERO);
        push_char(CHAR_BIN);
      end
      nta_pkg::KIND_UDEC16: begin
        push_decimal({16'd0, v[15:0]}, 1'b0);
      end
      default: ;
    endcase
    if (owed_text.size() > start) begin
      tail = owed_text.pop_back();
      tail[8] = 1'b1;
      owed_text.push_back(tail);
    end
  endfunction

  // Presents one number and returns once it has been taken. The text is
  // predicted as the item is presented; none of it can appear before then.
  task automatic send_number(input logic [2:0] k, input logic [31:0] v);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind     <= k;
    value    <= v;
    in_valid <= 1'b1;
    predict_text(k, v);
    numbers_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 99999);
      2: v = 32'd0 - $urandom_range(1, 99999);
      3: v = $urandom_range(0, 65535);
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'd99999 + $urandom_range(0, 2);
          3: v = 32'd0 - 32'd99999 - $urandom_range(0, 2);
          4: v = 32'hffff_ffff;
          default: v = 32'd0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [2:0] random_kind();
    if ($urandom_range(0, 99) < 92) return 3'($urandom_range(0, 5));
    return $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_number(random_kind(), random_value());
  endtask

  task automatic test_directed();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_number(nta_pkg::KIND_HEX16,  32'h0000_0000);
    send_number(nta_pkg::KIND_HEX16,  32'hffff_ffff);
    send_number(nta_pkg::KIND_HEX16,  32'h5a5a_abcd);
    send_number(nta_pkg::KIND_HEX8,   32'h0000_00ff);
    send_number(nta_pkg::KIND_HEX8,   32'h1234_5600);
    send_number(nta_pkg::KIND_HEX8,   32'h0000_009e);
    send_number(nta_pkg::KIND_SDEC,   32'd0);
    send_number(nta_pkg::KIND_SDEC,   32'd12345);
    send_number(nta_pkg::KIND_SDEC,   -32'sd1);
    send_number(nta_pkg::KIND_SDEC,   32'd99999);
    send_number(nta_pkg::KIND_SDEC,   32'd100000);
    send_number(nta_pkg::KIND_SDEC,   32'h8000_0000);
    send_number(nta_pkg::KIND_SDEC,   32'h7fff_ffff);
    send_number(nta_pkg::KIND_RDEC,   32'd0);
    send_number(nta_pkg::KIND_RDEC,   -32'sd7);
    send_number(nta_pkg::KIND_RDEC,   -32'sd99999);
    send_number(nta_pkg::KIND_RDEC,   32'h8000_0000);
    send_number(nta_pkg::KIND_RDEC,   32'd40302);
    send_number(nta_pkg::KIND_BIN8,   32'h0000_0000);
    send_number(nta_pkg::KIND_BIN8,   32'hffff_ffff);
    send_number(nta_pkg::KIND_BIN8,   32'h0000_00a5);
    send_number(nta_pkg::KIND_UDEC16, 32'h0000_0000);
    send_number(nta_pkg::KIND_UDEC16, 32'hffff_ffff);
    send_number(nta_pkg::KIND_UDEC16, 32'h0001_8000);
    send_number(KIND_SPARE6, 32'h1234_5678);
    send_number(KIND_SPARE7, 32'hffff_ffff);
  endtask

  // Back-to-back items into a receiver that never stalls.
  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(45);
  endtask

  // Random gaps on the input and random stalls on the output.
  task automatic test_random_idling();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_random(65);
  endtask

  // Stalling receiver fed without gaps, so the queue fills and in_ready drops.
  task automatic test_receiver_stalls();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    send_random(45);
  endtask

  always @(negedge clk) begin
    if (rx_idle_en && rx_stall_left == 0 && $urandom_range(0, 99) < 25)
      rx_stall_left = pick_gap();
    if (rx_stall_left != 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      chars_checked++;
      if (owed_text.size() == 0) begin
        $error("character 0x%02h with last=%0b arrived with nothing owed", character, last);
        error_count++;
      end else begin
        owed_char = owed_text.pop_front();
        if (character !== owed_char[7:0]) begin
          $error("character: expected 0x%02h, got 0x%02h", owed_char[7:0], character);
          error_count++;
        end
        if (last !== owed_char[8]) begin
          $error("last: expected %0b, got %0b", owed_char[8], last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d characters still owed", owed_text.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    value = '0;
    out_ready = 1'b0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_stall_left = 0;
    cycle_count = 0;
    error_count = 0;
    numbers_sent = 0;
    chars_checked = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_streaming();
    test_random_idling();
    test_receiver_stalls();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (owed_text.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d numbers over all six format kinds and the two spare codes,",
             numbers_sent);
    $display("and checked %0d characters with and without idling on either side.",
             chars_checked);
    if (error_count == 0 && owed_text.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> number_to_ascii_formatter.f
hdl/nta_pkg.sv
hdl/nta_front.sv
hdl/nta_queue.sv
hdl/nta_back.sv
hdl/number_to_ascii_formatter.sv
test/tb_top.sv
